@@ sv/plst_pkg.sv @@
// plst_pkg: shared constants, codes and types of the positional list engine
// no dependencies; imported by plst_seq and positional_list_engine
`default_nettype none

package plst_pkg;

	localparam int CAPACITY  = 32;
	localparam int ADDR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W     = $clog2(CAPACITY + 1);
	localparam int EXT_W     = CNT_W + 1;
	localparam int DATA_W    = 32;
	localparam int POS_W     = 8;
	localparam int OP_W      = 3;
	localparam int ST_W      = 2;
	localparam int OUT_CNT_W = 7;

	localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_END   = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_AT    = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
	localparam logic [OP_W-1:0] OP_DEL_END   = 3'd4;
	localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
	localparam logic [OP_W-1:0] OP_DUMP      = 3'd6;

	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
	localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_INS_RD,
		S_INS_WR,
		S_INS_PUT,
		S_DEL_CAP,
		S_DEL_RD,
		S_DEL_WR,
		S_DUMP_RD,
		S_DUMP_EMIT,
		S_RESP
	} state_t;

	// one result handed from the sequencer to the output register
	typedef struct packed {
		logic                        valid;
		logic signed [DATA_W-1:0]    value;
		logic [ST_W-1:0]             status;
		logic [OUT_CNT_W-1:0]        count;
		logic                        last;
	} res_t;

endpackage

`default_nettype wire

@@ sv/plst_ram.sv @@
// plst_ram: generic single write, single read RAM with registered read data
// no dependencies; holds the list cells
`default_nettype none

module plst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/plst_seq.sv @@
// plst_seq: sequencer that walks the cell RAM for insert, delete and dump
// depends on plst_pkg and plst_ram
`default_nettype none

module plst_seq (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [plst_pkg::OP_W-1:0]       op,
	input  wire logic [plst_pkg::POS_W-1:0]      position,
	input  wire logic signed [plst_pkg::DATA_W-1:0] item_value,
	input  wire logic                            emit_ok,
	output logic                                 idle,
	output plst_pkg::res_t                       res
);

	import plst_pkg::*;

	state_t state_q, state_d;

	logic [OP_W-1:0]          op_q;
	logic [POS_W-1:0]         pos_q;
	logic [DATA_W-1:0]        val_q;
	logic [CNT_W-1:0]         count_q;
	logic [ADDR_W-1:0]        ptr_q;
	logic [ADDR_W-1:0]        tgt_q;
	logic [DATA_W-1:0]        res_val_q;
	logic [ST_W-1:0]          res_st_q;

	logic                     ram_we, ram_re;
	logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
	logic [DATA_W-1:0]        ram_wdata, ram_rdata;

	logic                     is_ins, is_del, is_dump, empty, full;
	logic                     ins_badpos, del_badpos;
	logic [POS_W:0]           pos_x, cnt_px;
	logic [EXT_W-1:0]         cnt_x, ptr_x, ptr_p1, ptr_p2, ptr_m1;
	logic [ADDR_W-1:0]        pos_idx, cnt_idx, last_idx, ins_idx, del_idx;
	logic                     del_more_cap, del_more_wr, dump_last;

	plst_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// decode and the shared pointer step
	always_comb begin
		is_ins  = op_q inside {OP_INS_FRONT, OP_INS_END, OP_INS_AT};
		is_del  = op_q inside {OP_DEL_FRONT, OP_DEL_END, OP_DEL_AT};
		is_dump = (op_q == OP_DUMP);
		empty   = (count_q == '0);
		full    = (count_q >= CNT_W'(CAPACITY));
		pos_x   = {1'b0, pos_q};
		cnt_px  = (POS_W + 1)'(count_q);
		ins_badpos = (op_q == OP_INS_AT) &&
			((pos_q == '0) || (pos_x > cnt_px + (POS_W + 1)'(1)));
		del_badpos = (op_q == OP_DEL_AT) && ((pos_q == '0) || (pos_x > cnt_px));
		pos_idx  = ADDR_W'(pos_q - POS_W'(1));
		cnt_idx  = ADDR_W'(count_q);
		last_idx = ADDR_W'(count_q - CNT_W'(1));
		case (op_q)
			OP_INS_FRONT: ins_idx = '0;
			OP_INS_END:   ins_idx = cnt_idx;
			default:      ins_idx = pos_idx;
		endcase
		case (op_q)
			OP_DEL_FRONT: del_idx = '0;
			OP_DEL_END:   del_idx = last_idx;
			default:      del_idx = pos_idx;
		endcase
		cnt_x  = EXT_W'(count_q);
		ptr_x  = EXT_W'(ptr_q);
		ptr_p1 = ptr_x + EXT_W'(1);
		ptr_p2 = ptr_x + EXT_W'(2);
		ptr_m1 = ptr_x - EXT_W'(1);
		del_more_cap = (ptr_p1 < cnt_x);
		del_more_wr  = (ptr_p2 < cnt_x);
		dump_last    = (ptr_p1 == cnt_x);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (is_ins) begin
					if (ins_badpos || full) state_d = S_RESP;
					else if (ins_idx == cnt_idx) state_d = S_INS_PUT;
					else state_d = S_INS_RD;
				end else if (is_del) begin
					if (empty || del_badpos) state_d = S_RESP;
					else state_d = S_DEL_CAP;
				end else if (is_dump) begin
					if (empty) state_d = S_RESP;
					else state_d = S_DUMP_RD;
				end else begin
					state_d = S_RESP;
				end
			end
			S_INS_RD: state_d = S_INS_WR;
			S_INS_WR: begin
				if (ptr_m1 == EXT_W'(tgt_q)) state_d = S_INS_PUT;
				else state_d = S_INS_RD;
			end
			S_INS_PUT: state_d = S_RESP;
			S_DEL_CAP: begin
				if (del_more_cap) state_d = S_DEL_RD;
				else state_d = S_RESP;
			end
			S_DEL_RD: state_d = S_DEL_WR;
			S_DEL_WR: begin
				if (del_more_wr) state_d = S_DEL_RD;
				else state_d = S_RESP;
			end
			S_DUMP_RD: state_d = S_DUMP_EMIT;
			S_DUMP_EMIT: begin
				if (emit_ok) state_d = dump_last ? S_IDLE : S_DUMP_RD;
			end
			S_RESP: begin
				if (emit_ok) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ram controls and result
	always_comb begin
		idle      = (state_q == S_IDLE);
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = ram_rdata;
		ram_raddr = ptr_q;
		res.valid  = 1'b0;
		res.value  = res_val_q;
		res.status = res_st_q;
		res.count  = OUT_CNT_W'(count_q);
		res.last   = 1'b1;
		case (state_q)
			S_CHECK: begin
				ram_re    = is_del && !empty && !del_badpos;
				ram_raddr = del_idx;
			end
			S_INS_RD: begin
				ram_re    = 1'b1;
				ram_raddr = ADDR_W'(ptr_m1);
			end
			S_INS_WR: ram_we = 1'b1;
			S_INS_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = tgt_q;
				ram_wdata = val_q;
			end
			S_DEL_RD: begin
				ram_re    = 1'b1;
				ram_raddr = ADDR_W'(ptr_p1);
			end
			S_DEL_WR: ram_we = 1'b1;
			S_DUMP_RD: ram_re = 1'b1;
			S_DUMP_EMIT: begin
				res.valid  = emit_ok;
				res.value  = ram_rdata;
				res.status = ST_OK;
				res.last   = dump_last;
			end
			S_RESP: res.valid = emit_ok;
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_INS_PUT) begin
				count_q <= count_q + CNT_W'(1);
			end else if ((state_q == S_DEL_CAP && !del_more_cap) ||
			             (state_q == S_DEL_WR && !del_more_wr)) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// operands, pointers and pending result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op_q  <= op;
					pos_q <= position;
					val_q <= item_value;
				end
			end
			S_CHECK: begin
				res_val_q <= '0;
				if (is_ins) begin
					res_st_q <= ins_badpos ? ST_BADPOS : (full ? ST_FULL : ST_OK);
				end else if (is_del) begin
					res_st_q <= empty ? ST_EMPTY : (del_badpos ? ST_BADPOS : ST_OK);
				end else if (is_dump) begin
					res_st_q <= ST_EMPTY;
				end else begin
					res_st_q <= ST_OK;
				end
				tgt_q <= is_ins ? ins_idx : del_idx;
				ptr_q <= is_ins ? cnt_idx : (is_dump ? '0 : del_idx);
			end
			S_INS_WR:  ptr_q <= ADDR_W'(ptr_m1);
			S_DEL_CAP: res_val_q <= ram_rdata;
			S_DEL_WR:  ptr_q <= ADDR_W'(ptr_p1);
			S_DUMP_EMIT: begin
				if (emit_ok && !dump_last) ptr_q <= ADDR_W'(ptr_p1);
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

@@ sv/positional_list_engine.sv @@
// positional_list_engine: top level, input handshake and output register
// depends on plst_pkg and plst_seq (which holds plst_ram)
//
// channel  | signals                                         | moves
// ---------+-------------------------------------------------+---------------------------
// input    | in_valid, in_ready, op, position, item_value    | one operation per transfer
// output   | out_valid, out_ready, result_value, status,     | one result per transfer,
//          | element_count, last_of_run                      | last_of_run on the final one
//
// insert moves each element from the position on back one cell, and delete moves
// each element after it forward; dump reads then emits each element; rejected ops
// and unused codes go straight to the status result; each op ends in idle, which
// takes the next transfer; each moved element costs a read then a write on the cell ram, whose read data is registered
// reset clears the sequencer and the element count; cells need no clearing
// in_ready is high only while the sequencer is idle; a stalled output
// register holds the walk at the next result
`default_nettype none

module positional_list_engine (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [plst_pkg::OP_W-1:0]           op,
	input  wire logic [plst_pkg::POS_W-1:0]          position,
	input  wire logic signed [plst_pkg::DATA_W-1:0]  item_value,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [plst_pkg::DATA_W-1:0]       result_value,
	output logic [plst_pkg::ST_W-1:0]                status,
	output logic [plst_pkg::OUT_CNT_W-1:0]           element_count,
	output logic                                     last_of_run
);

	import plst_pkg::*;

	logic  idle;
	logic  emit_ok;
	res_t  res;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] result_value_q;
	logic [ST_W-1:0]          status_q;
	logic [OUT_CNT_W-1:0]     element_count_q;
	logic                     last_of_run_q;

	// a new result may load when the output register is empty or draining
	assign emit_ok  = !out_valid_q || out_ready;
	assign in_ready = idle;

	plst_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (in_valid && in_ready),
		.op         (op),
		.position   (position),
		.item_value (item_value),
		.emit_ok    (emit_ok),
		.idle       (idle),
		.res        (res)
	);

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (res.valid) begin
			result_value_q  <= res.value;
			status_q        <= res.status;
			element_count_q <= res.count;
			last_of_run_q   <= res.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_value  = result_value_q;
	assign status        = status_q;
	assign element_count = element_count_q;
	assign last_of_run   = last_of_run_q;

`ifndef SYNTH
	// the sequencer goes busy right after taking an operation
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready high the cycle after an input transfer");

	// the list never holds more than its capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (element_count <= OUT_CNT_W'(CAPACITY)))
		else $error("element_count above capacity");

	// full is reported only on a full list, empty only on an empty one
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_FULL) |-> (element_count == OUT_CNT_W'(CAPACITY)))
		else $error("full status with room left");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_EMPTY) |-> (element_count == '0))
		else $error("empty status on a non-empty list");

	// only dump results may be non-final, and those are always ok
	a_run_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_of_run) |-> (status == ST_OK))
		else $error("non-final result with error status");
`endif

endmodule

`default_nettype wire
